[src/nadu_pkg.sv]
// Shared types, sizes and exponential tables for the neuron activation and delta unit.
package nadu_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int INPUT_BITS = 12;
    localparam int ERROR_BITS = 16;
    localparam int DERIV_BITS = FRAC_BITS + 1;

    // exponent argument: |x| for sigmoid, 2|x| for tanh
    localparam int ARG_BITS = INPUT_BITS + 1;
    localparam int LO_BITS  = (ARG_BITS + 1) / 2;
    localparam int HI_BITS  = ARG_BITS - LO_BITS;
    localparam int LO_DEPTH = 2 ** LO_BITS;
    localparam int HI_DEPTH = 2 ** HI_BITS;

    // e^-a held as Q1.32
    localparam int EXP_FRAC = 32;
    localparam int EXP_BITS = EXP_FRAC + 1;
    localparam int DEN_BITS = EXP_FRAC + 2;
    localparam int REM_BITS = EXP_FRAC + 3;

    // weight of one input LSB as a real, for table generation
    localparam real ARG_LSB = 1.0 / real'(2 ** FRAC_BITS);

    // quotient floor(2^(FRAC_BITS+1) * 2 / (1 + e)) covers both sigmoid and tanh
    localparam int QUO_BITS = FRAC_BITS + 3;

    localparam logic [DERIV_BITS-1:0] DERIV_ONE = DERIV_BITS'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        ACT_SIGMOID  = 2'd0,
        ACT_TANH     = 2'd1,
        ACT_RELU     = 2'd2,
        ACT_IDENTITY = 2'd3
    } act_mode_t;

    typedef struct packed {
        logic signed [INPUT_BITS-1:0] pre_activation;
        logic signed [ERROR_BITS-1:0] error_in;
    } nadu_in_t;

    typedef struct packed {
        logic signed [INPUT_BITS-1:0] activation_out;
        logic        [DERIV_BITS-1:0] derivative_out;
        logic signed [ERROR_BITS-1:0] delta_out;
    } nadu_out_t;

    typedef struct packed {
        act_mode_t                    mode;
        logic signed [INPUT_BITS-1:0] x;
        logic signed [ERROR_BITS-1:0] err;
    } nadu_carry_t;

    typedef logic [EXP_BITS-1:0] exp_word_t;
    typedef exp_word_t [HI_DEPTH-1:0] exp_hi_table_t;
    typedef exp_word_t [LO_DEPTH-1:0] exp_lo_table_t;

    // e^-arg scaled by 2^EXP_FRAC, rounded; elaboration only
    function automatic exp_word_t exp_fixed(real arg);
        real scaled;
        scaled = $exp(-arg) * (2.0 ** EXP_FRAC);
        return exp_word_t'(longint'(scaled));
    endfunction

    // coarse steps: e^-(i * 2^LO_BITS / 2^FRAC_BITS)
    function automatic exp_hi_table_t build_exp_hi();
        exp_hi_table_t t;
        for (int i = 0; i < HI_DEPTH; i++)
        begin
            t[i] = exp_fixed(real'(i * LO_DEPTH) * ARG_LSB);
        end
        return t;
    endfunction

    // fine steps: e^-(i / 2^FRAC_BITS)
    function automatic exp_lo_table_t build_exp_lo();
        exp_lo_table_t t;
        for (int i = 0; i < LO_DEPTH; i++)
        begin
            t[i] = exp_fixed(real'(i) * ARG_LSB);
        end
        return t;
    endfunction

    localparam exp_hi_table_t EXP_HI_TABLE = build_exp_hi();
    localparam exp_lo_table_t EXP_LO_TABLE = build_exp_lo();

endpackage

[src/neuron_activation_delta_unit_core.sv]
// Pipelined neuron activation, derivative and delta unit (top level).
//
// One word in carries a Q4.8 pre-activation x and a Q8.8 error. One word out
// carries the activation y (sigmoid, tanh, relu or identity of x, picked by the
// two-bit mode register, rounded to nearest Q4.8), the derivative taken from y
// in Q1.8 (256 is one) and the delta, error times derivative shifted right
// arithmetically by 8. The unit accepts a word every cycle unless a stalled
// output has backed up the full pipe. There are 17 register stages: one input
// stage, a table lookup of e^-a split into coarse and fine factors, one
// 33x33 multiply that joins them, an 11-stage restoring divider that forms
// 2^10/(1+e^-a) one quotient bit per stage, then activation, derivative
// and delta stages. Every stage holds a valid bit and moves whenever the
// stage after it is free, so bubbles are squeezed out and a stalled output
// only backs up the input once the whole pipe is full. The mode is sampled
// with each word; write it through the config channel (always ready) while
// idle.
module neuron_activation_delta_unit_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  nadu_pkg::nadu_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output nadu_pkg::nadu_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data
);

    localparam int INPUT_BITS = nadu_pkg::INPUT_BITS;
    localparam int ERROR_BITS = nadu_pkg::ERROR_BITS;
    localparam int FRAC_BITS  = nadu_pkg::FRAC_BITS;
    localparam int DERIV_BITS = nadu_pkg::DERIV_BITS;
    localparam int ARG_BITS   = nadu_pkg::ARG_BITS;
    localparam int LO_BITS    = nadu_pkg::LO_BITS;
    localparam int EXP_FRAC   = nadu_pkg::EXP_FRAC;
    localparam int EXP_BITS   = nadu_pkg::EXP_BITS;
    localparam int DEN_BITS   = nadu_pkg::DEN_BITS;
    localparam int REM_BITS   = nadu_pkg::REM_BITS;
    localparam int QUO_BITS   = nadu_pkg::QUO_BITS;
    localparam int PROD_BITS  = 2 * EXP_BITS;
    localparam int DPROD_BITS = 2 * DERIV_BITS;
    localparam int DELTA_BITS = ERROR_BITS + DERIV_BITS + 1;

    // stage map
    localparam int ST_LOOKUP  = 1;
    localparam int ST_EXP     = 2;
    localparam int ST_DIV0    = 3;
    localparam int ST_ACT     = ST_DIV0 + QUO_BITS;
    localparam int ST_DERIV   = ST_ACT + 1;
    localparam int ST_OUT     = ST_DERIV + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    localparam logic [REM_BITS-1:0]   REM_ONE  = REM_BITS'(1) << EXP_FRAC;
    localparam logic [DEN_BITS-1:0]   DEN_ONE  = DEN_BITS'(1) << EXP_FRAC;
    localparam logic [PROD_BITS-1:0]  PROD_RND = PROD_BITS'(1) << (EXP_FRAC - 1);
    localparam logic [QUO_BITS-1:0]   QUO_ONE  = QUO_BITS'(1) << FRAC_BITS;
    localparam logic signed [INPUT_BITS-1:0] Y_ONE = INPUT_BITS'(1) << FRAC_BITS;

    // ---------------------------------------------------------------
    // mode register
    // ---------------------------------------------------------------
    nadu_pkg::act_mode_t mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= nadu_pkg::ACT_SIGMOID;
        end
        else if (cfg_valid)
        begin
            mode_reg <= nadu_pkg::act_mode_t'(cfg_data);
        end
    end

    // ---------------------------------------------------------------
    // pipeline control: a stage moves when empty or when the next one moves
    // ---------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] advance;

    always_comb
    begin
        advance[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            advance[i] = !valid_reg[i] || advance[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = advance[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = advance[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !advance[0];
    assign out_valid = valid_reg[ST_OUT];

    // ---------------------------------------------------------------
    // x, error and mode ride along with each word
    // ---------------------------------------------------------------
    nadu_pkg::nadu_carry_t carry_reg [ST_DERIV+1];

    always_ff @(posedge clk)
    begin
        if (advance[0])
        begin
            carry_reg[0].mode <= mode_reg;
            carry_reg[0].x    <= in_data.pre_activation;
            carry_reg[0].err  <= in_data.error_in;
        end
    end

    for (genvar s = 1; s <= ST_DERIV; s++)
    begin : g_carry
        always_ff @(posedge clk)
        begin
            if (advance[s])
            begin
                carry_reg[s] <= carry_reg[s-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // lookup: e^-a = coarse(a_hi) * fine(a_lo)
    // ---------------------------------------------------------------
    logic [INPUT_BITS-1:0]   lk_mag;
    logic [ARG_BITS-1:0]     lk_arg;
    nadu_pkg::exp_word_t     hi_word_reg;
    nadu_pkg::exp_word_t     lo_word_reg;

    always_comb
    begin
        lk_mag = carry_reg[ST_LOOKUP-1].x[INPUT_BITS-1] ?
                 INPUT_BITS'(-carry_reg[ST_LOOKUP-1].x) :
                 INPUT_BITS'(carry_reg[ST_LOOKUP-1].x);
        if (carry_reg[ST_LOOKUP-1].mode == nadu_pkg::ACT_TANH)
        begin
            lk_arg = {lk_mag, 1'b0};
        end
        else
        begin
            lk_arg = {1'b0, lk_mag};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance[ST_LOOKUP])
        begin
            hi_word_reg <= nadu_pkg::EXP_HI_TABLE[lk_arg[ARG_BITS-1:LO_BITS]];
            lo_word_reg <= nadu_pkg::EXP_LO_TABLE[lk_arg[LO_BITS-1:0]];
        end
    end

    // ---------------------------------------------------------------
    // join the two factors, round back to Q1.32
    // ---------------------------------------------------------------
    logic [PROD_BITS-1:0] exp_prod;
    logic [PROD_BITS-1:0] exp_rnd;
    logic [EXP_BITS-1:0]  exp_reg;

    assign exp_prod = PROD_BITS'(hi_word_reg) * PROD_BITS'(lo_word_reg);
    assign exp_rnd  = exp_prod + PROD_RND;

    always_ff @(posedge clk)
    begin
        if (advance[ST_EXP])
        begin
            exp_reg <= exp_rnd[EXP_FRAC +: EXP_BITS];
        end
    end

    // ---------------------------------------------------------------
    // restoring divider: q = floor(2^(QUO_BITS-1) / (1 + e)), one bit per stage
    // ---------------------------------------------------------------
    logic [REM_BITS-1:0] rem_reg [QUO_BITS-1];
    logic [DEN_BITS-1:0] den_reg [QUO_BITS-1];
    logic [QUO_BITS-1:0] quo_reg [QUO_BITS];

    for (genvar j = 0; j < QUO_BITS; j++)
    begin : g_div
        logic [REM_BITS-1:0] r_try;
        logic [DEN_BITS-1:0] d_cur;
        logic [QUO_BITS-1:0] q_prev;
        logic [REM_BITS-1:0] r_left;
        logic                take;

        if (j == 0)
        begin : g_first
            assign r_try  = REM_ONE;
            assign d_cur  = DEN_ONE + DEN_BITS'(exp_reg);
            assign q_prev = '0;
        end
        else
        begin : g_next
            assign r_try  = {rem_reg[j-1][REM_BITS-2:0], 1'b0};
            assign d_cur  = den_reg[j-1];
            assign q_prev = quo_reg[j-1];
        end

        assign take   = r_try >= REM_BITS'(d_cur);
        assign r_left = take ? (r_try - REM_BITS'(d_cur)) : r_try;

        always_ff @(posedge clk)
        begin
            if (advance[ST_DIV0+j])
            begin
                quo_reg[j] <= {q_prev[QUO_BITS-2:0], take};
            end
        end

        if (j < QUO_BITS - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (advance[ST_DIV0+j])
                begin
                    rem_reg[j] <= r_left;
                    den_reg[j] <= d_cur;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // activation
    // ---------------------------------------------------------------
    logic [QUO_BITS-1:0]           act_q;
    logic [QUO_BITS-1:0]           sig_sum;
    logic [QUO_BITS:0]             tan_sum;
    logic [QUO_BITS-1:0]           tan_mag;
    logic signed [INPUT_BITS-1:0]  sig_y;
    logic signed [INPUT_BITS-1:0]  tan_y;
    logic signed [INPUT_BITS-1:0]  act_x;
    logic                          act_neg;
    logic signed [INPUT_BITS-1:0]  act_y;
    logic signed [INPUT_BITS-1:0]  act_y_reg;

    always_comb
    begin
        act_q   = quo_reg[QUO_BITS-1];
        act_x   = carry_reg[ST_ACT-1].x;
        act_neg = act_x[INPUT_BITS-1];
        // sigmoid: round(2^F/(1+e)) from the quotient with one bit dropped
        sig_sum = {1'b0, act_q[QUO_BITS-1:1]} + QUO_BITS'(1);
        sig_y   = INPUT_BITS'(sig_sum[QUO_BITS-1:1]);
        // tanh: round(2^(F+1)/(1+e^-2a)) - one
        tan_sum = {1'b0, act_q} + (QUO_BITS+1)'(1);
        tan_mag = tan_sum[QUO_BITS:1] - QUO_ONE;
        tan_y   = INPUT_BITS'(tan_mag);
        case (carry_reg[ST_ACT-1].mode)
            nadu_pkg::ACT_SIGMOID:  act_y = act_neg ? (Y_ONE - sig_y) : sig_y;
            nadu_pkg::ACT_TANH:     act_y = act_neg ? -tan_y : tan_y;
            nadu_pkg::ACT_RELU:     act_y = (!act_neg && act_x != '0) ? act_x : '0;
            default:                act_y = act_x;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance[ST_ACT])
        begin
            act_y_reg <= act_y;
        end
    end

    // ---------------------------------------------------------------
    // derivative from y
    // ---------------------------------------------------------------
    logic [DERIV_BITS-1:0]          der_mag;
    logic [DERIV_BITS-1:0]          der_a;
    logic [DERIV_BITS-1:0]          der_b;
    logic [DPROD_BITS-1:0]          der_prod;
    logic [DERIV_BITS-1:0]          der_sh;
    logic [DERIV_BITS-1:0]          der_d;
    logic signed [INPUT_BITS-1:0]   der_x;
    logic signed [INPUT_BITS-1:0]   der_y_reg;
    logic [DERIV_BITS-1:0]          der_d_reg;

    always_comb
    begin
        der_x   = carry_reg[ST_DERIV-1].x;
        der_mag = act_y_reg[INPUT_BITS-1] ? DERIV_BITS'(-act_y_reg) : DERIV_BITS'(act_y_reg);
        if (carry_reg[ST_DERIV-1].mode == nadu_pkg::ACT_SIGMOID)
        begin
            der_a = DERIV_BITS'(act_y_reg);
            der_b = nadu_pkg::DERIV_ONE - DERIV_BITS'(act_y_reg);
        end
        else
        begin
            der_a = der_mag;
            der_b = der_mag;
        end
        der_prod = DPROD_BITS'(der_a) * DPROD_BITS'(der_b);
        der_sh   = der_prod[FRAC_BITS +: DERIV_BITS];
        case (carry_reg[ST_DERIV-1].mode)
            nadu_pkg::ACT_SIGMOID: der_d = der_sh;
            nadu_pkg::ACT_TANH:    der_d = nadu_pkg::DERIV_ONE - der_sh;
            nadu_pkg::ACT_RELU:
                der_d = (!der_x[INPUT_BITS-1] && der_x != '0) ? nadu_pkg::DERIV_ONE : '0;
            default:               der_d = nadu_pkg::DERIV_ONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance[ST_DERIV])
        begin
            der_y_reg <= act_y_reg;
            der_d_reg <= der_d;
        end
    end

    // ---------------------------------------------------------------
    // delta = floor(err * d / 2^F), output register
    // ---------------------------------------------------------------
    logic signed [DELTA_BITS-1:0] dl_prod;
    nadu_pkg::nadu_out_t          out_data_reg;

    assign dl_prod = $signed(carry_reg[ST_DERIV].err) * $signed({1'b0, der_d_reg});

    always_ff @(posedge clk)
    begin
        if (advance[ST_OUT])
        begin
            out_data_reg.activation_out <= der_y_reg;
            out_data_reg.derivative_out <= der_d_reg;
            out_data_reg.delta_out      <= dl_prod[FRAC_BITS +: ERROR_BITS];
        end
    end

    assign out_data = out_data_reg;

endmodule

[src/nadu_core_check.sv]
// Port-level assertions for the activation unit, bound to the top level.
module nadu_core_check (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input nadu_pkg::nadu_in_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input nadu_pkg::nadu_out_t out_data,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [1:0]          cfg_data
);

    // held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // pipe drains freely, so a free output never backs up the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled with output free");

    a_deriv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.derivative_out <= nadu_pkg::DERIV_ONE)
        else $error("derivative above one");

    a_zero_delta: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.derivative_out == '0 |-> out_data.delta_out == '0)
        else $error("nonzero delta with zero derivative");

endmodule

bind neuron_activation_delta_unit_core nadu_core_check u_nadu_core_check (.*);
